### hw/rtl/fpsc_pkg.sv
package fpsc_pkg;

  // Burst store depth
  localparam int unsigned BufBytesDef = 30;

  // Field widths
  localparam int unsigned KindW    = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned SpeedW   = 7;
  localparam int unsigned CauseW   = 2;
  localparam int unsigned WordW    = 16;
  localparam int unsigned DzW      = 15;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Item kinds
  localparam logic [KindW-1:0] KindByte = 2'd0;
  localparam logic [KindW-1:0] KindIdle = 2'd1;
  localparam logic [KindW-1:0] KindTick = 2'd2;

  // Result causes
  localparam logic [CauseW-1:0] CauseTrack   = 2'd0;
  localparam logic [CauseW-1:0] CauseLost    = 2'd1;
  localparam logic [CauseW-1:0] CauseTimeout = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDeadZone  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBaseSpeed = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxTurn   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTimeout   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinLen    = 3'd4;

  // Register reset values
  localparam logic [DzW-1:0]      DeadZoneRst  = 15'd10;
  localparam logic [SpeedW-1:0]   BaseSpeedRst = 7'd60;
  localparam logic [SpeedW-1:0]   MaxTurnRst   = 7'd40;
  localparam logic [TimeoutW-1:0] TimeoutRst   = 16'd1000;
  localparam logic [LenW-1:0]     MinLenRst    = 5'd9;

  // Frame format
  localparam logic [WordW-1:0] HeaderWord  = 16'h55AA;
  localparam logic [ByteW-1:0] EndByte     = 8'h0D;
  localparam logic [ByteW-1:0] StatusTrack = 8'h00;
  localparam logic [ByteW-1:0] StatusLost  = 8'h01;
  localparam logic [LenW-1:0]  MinLenFloor = 5'd9;
  localparam int unsigned PosHeaderHi = 0;
  localparam int unsigned PosHeaderLo = 1;
  localparam int unsigned PosErrLo    = 2;
  localparam int unsigned PosErrHi    = 3;
  localparam int unsigned PosStatus   = 6;

  // Steering: 2*m/5 == (m * 0xCCCD) >> 17 for every 16-bit m
  localparam logic [WordW-1:0]  Recip5     = 16'hCCCD;
  localparam int unsigned       Recip5Shr  = 17;
  localparam logic [SpeedW-1:0] SpeedMax   = 7'd100;

  typedef struct packed {
    logic [DzW-1:0]      dz_band;
    logic [SpeedW-1:0]   cruise_pct;
    logic [SpeedW-1:0]   turn_limit;
    logic [TimeoutW-1:0] lost_timeout;
    logic [LenW-1:0]     min_frame_len;
  } cfg_t;

  // Action decided for the held item
  typedef struct packed {
    logic              fire;
    logic              drive;
    logic [CauseW-1:0] cause;
  } act_t;

endpackage

### hw/rtl/fpsc_intf.sv
interface fpsc_in_if
  import fpsc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface fpsc_out_if
  import fpsc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] left_pct;
  logic [SpeedW-1:0] right_pct;
  logic [CauseW-1:0] cause;

  modport source (output valid, left_pct, right_pct, cause, input ready);
  modport sink   (input valid, left_pct, right_pct, cause, output ready);
endinterface

interface fpsc_cfg_if
  import fpsc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/frame_parse_steering_control.sv
// An accepted item is held in the input register; when it moves on, its result,
// if any, is loaded into the result register, from which it transfers out.
// Throughput: one item per cycle; the input stalls only while the held item
// makes a result, the result register is full and the sink is not taking it.
// Reset (rst_ni, async, active low): registers to their default values,
// burst bookkeeping and lost counter cleared, both registers empty.
module frame_parse_steering_control
  import fpsc_pkg::*;
#(
  parameter int unsigned BufBytes = BufBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fpsc_in_if.sink     in_i,
  fpsc_out_if.source  out_o,
  fpsc_cfg_if.sink    cfg_i
);

  // Input register: holds one item while the parser decides on it
  logic             in_valid_q;
  logic [KindW-1:0] kind_q;
  logic [ByteW-1:0] byte_q;

  // Result register
  logic              out_valid_q;
  logic [SpeedW-1:0] left_q;
  logic [SpeedW-1:0] right_q;
  logic [CauseW-1:0] cause_q;

  cfg_t              cfg;
  act_t              act;
  logic [WordW-1:0]  error_word;
  logic [SpeedW-1:0] steer_left;
  logic [SpeedW-1:0] steer_right;
  logic              out_free;
  logic              step;

  fpsc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .cfg_o  (cfg)
  );

  // Parser state commits only when the held item moves on (step)
  fpsc_frame #(
    .BufBytes (BufBytes)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .kind_i       (kind_q),
    .byte_i       (byte_q),
    .cfg_i        (cfg),
    .act_o        (act),
    .error_word_o (error_word)
  );

  fpsc_steer u_steer (
    .error_word_i (error_word),
    .cfg_i        (cfg),
    .left_o       (steer_left),
    .right_o      (steer_right)
  );

  // The result register frees up in the same cycle its content transfers out.
  // An item with no result always moves on; one with a result needs room.
  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && (!act.fire || out_free);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      kind_q <= in_i.kind;
      byte_q <= in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && act.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Brake results carry zero speeds
  always_ff @(posedge clk_i) begin
    if (step && act.fire) begin
      left_q  <= act.drive ? steer_left  : '0;
      right_q <= act.drive ? steer_right : '0;
      cause_q <= act.cause;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_pct  = left_q;
  assign out_o.right_pct = right_q;
  assign out_o.cause     = cause_q;

endmodule

### hw/rtl/fpsc_cfg_regs.sv
module fpsc_cfg_regs
  import fpsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  fpsc_cfg_if.sink   cfg,
  output cfg_t       cfg_o
);

  cfg_t regs_q, regs_d;

  assign cfg.ready = 1'b1;
  assign cfg_o     = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg.valid) begin
      unique case (cfg.index)
        RegDeadZone:  regs_d.dz_band       = cfg.data[DzW-1:0];
        RegBaseSpeed: regs_d.cruise_pct    = cfg.data[SpeedW-1:0];
        RegMaxTurn:   regs_d.turn_limit    = cfg.data[SpeedW-1:0];
        RegTimeout:   regs_d.lost_timeout  = cfg.data[TimeoutW-1:0];
        RegMinLen:    regs_d.min_frame_len = cfg.data[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.dz_band       <= DeadZoneRst;
      regs_q.cruise_pct    <= BaseSpeedRst;
      regs_q.turn_limit    <= MaxTurnRst;
      regs_q.lost_timeout  <= TimeoutRst;
      regs_q.min_frame_len <= MinLenRst;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

### hw/rtl/fpsc_frame.sv
module fpsc_frame
  import fpsc_pkg::*;
#(
  parameter int unsigned BufBytes = BufBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [KindW-1:0] kind_i,
  input  logic [ByteW-1:0] byte_i,
  input  cfg_t             cfg_i,
  output act_t             act_o,
  output logic [WordW-1:0] error_word_o
);

  localparam int unsigned CntW = $clog2(BufBytes + 1);

  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [WordW-1:0]    header_q, header_d;
  logic [WordW-1:0]    error_q, error_d;
  logic [ByteW-1:0]    status_q, status_d;
  logic [ByteW-1:0]    sum_q, sum_d;
  logic [ByteW-1:0]    prev_q, prev_d;
  logic [ByteW-1:0]    last_q, last_d;
  logic [WordW-1:0]    lost_q, lost_d;
  logic [LenW-1:0]     min_len;
  logic [ByteW-1:0]    body_sum;
  logic                frame_ok;
  logic [WordW:0]      lost_next;
  act_t                act;

  assign min_len   = (cfg_i.min_frame_len < MinLenFloor) ? MinLenFloor
                                                          : cfg_i.min_frame_len;
  // sum of all bytes ahead of the checksum byte
  assign body_sum  = sum_q - prev_q - last_q;
  assign frame_ok  = (LenW'(cnt_q) >= min_len) && (header_q == HeaderWord) &&
                     (last_q == EndByte) && (body_sum == prev_q);
  assign lost_next = {1'b0, lost_q} + (WordW+1)'(1);

  always_comb begin
    cnt_d    = cnt_q;
    header_d = header_q;
    error_d  = error_q;
    status_d = status_q;
    sum_d    = sum_q;
    prev_d   = prev_q;
    last_d   = last_q;
    lost_d   = lost_q;
    act      = '0;
    unique case (kind_i)
      KindByte: begin
        if (cnt_q < CntW'(BufBytes)) begin
          unique case (cnt_q)
            CntW'(PosHeaderHi): header_d = {byte_i, header_q[ByteW-1:0]};
            CntW'(PosHeaderLo): header_d = {header_q[WordW-1:ByteW], byte_i};
            CntW'(PosErrLo):    error_d  = {error_q[WordW-1:ByteW], byte_i};
            CntW'(PosErrHi):    error_d  = {byte_i, error_q[ByteW-1:0]};
            CntW'(PosStatus):   status_d = byte_i;
            default: ;
          endcase
          sum_d  = sum_q + byte_i;
          prev_d = last_q;
          last_d = byte_i;
          cnt_d  = cnt_q + CntW'(1);
        end
      end
      KindIdle: begin
        cnt_d  = '0;
        sum_d  = '0;
        prev_d = '0;
        last_d = '0;
        if (frame_ok) begin
          if (status_q == StatusTrack) begin
            lost_d    = '0;
            act.fire  = 1'b1;
            act.drive = 1'b1;
            act.cause = CauseTrack;
          end else if (status_q == StatusLost && lost_q == '0) begin
            lost_d    = WordW'(1);
            act.fire  = 1'b1;
            act.cause = CauseLost;
          end
        end
      end
      KindTick: begin
        if (lost_q != '0) begin
          if (lost_next > {1'b0, cfg_i.lost_timeout} || lost_next[WordW]) begin
            lost_d    = '0;
            act.fire  = 1'b1;
            act.cause = CauseTimeout;
          end else begin
            lost_d = lost_next[WordW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      header_q <= '0;
      error_q  <= '0;
      status_q <= '0;
      sum_q    <= '0;
      prev_q   <= '0;
      last_q   <= '0;
      lost_q   <= '0;
    end else if (step_i) begin
      cnt_q    <= cnt_d;
      header_q <= header_d;
      error_q  <= error_d;
      status_q <= status_d;
      sum_q    <= sum_d;
      prev_q   <= prev_d;
      last_q   <= last_d;
      lost_q   <= lost_d;
    end
  end

  assign act_o        = act;
  assign error_word_o = error_q;

endmodule

### hw/rtl/fpsc_steer.sv
module fpsc_steer
  import fpsc_pkg::*;
(
  input  logic [WordW-1:0]  error_word_i,
  input  cfg_t              cfg_i,
  output logic [SpeedW-1:0] left_o,
  output logic [SpeedW-1:0] right_o
);

  logic [WordW-1:0]      mag;
  logic                  in_dz;
  logic [2*WordW-1:0]    prod;
  logic [WordW-1:0]      turn;
  logic [SpeedW-1:0]     tmag;
  logic signed [SpeedW+1:0] plus, minus;

  function automatic logic [SpeedW-1:0] clamp_speed(logic signed [SpeedW+1:0] v);
    logic [SpeedW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, SpeedMax})) begin
      r = SpeedMax;
    end else begin
      r = v[SpeedW-1:0];
    end
    return r;
  endfunction

  // |x|; the most negative error gives 0x8000, still right as unsigned
  assign mag   = error_word_i[WordW-1] ? (~error_word_i + WordW'(1)) : error_word_i;
  assign in_dz = mag < {1'b0, cfg_i.dz_band};
  assign prod  = (2*WordW)'(mag) * (2*WordW)'(Recip5);
  assign turn  = WordW'(prod >> Recip5Shr);

  always_comb begin
    if (in_dz) begin
      tmag = '0;
    end else if (turn > WordW'(cfg_i.turn_limit)) begin
      tmag = cfg_i.turn_limit;
    end else begin
      tmag = turn[SpeedW-1:0];
    end
  end

  assign plus  = $signed({2'b00, cfg_i.cruise_pct}) + $signed({2'b00, tmag});
  assign minus = $signed({2'b00, cfg_i.cruise_pct}) - $signed({2'b00, tmag});

  // negative error steers left wheel up
  assign left_o  = error_word_i[WordW-1] ? clamp_speed(plus) : clamp_speed(minus);
  assign right_o = error_word_i[WordW-1] ? clamp_speed(minus) : clamp_speed(plus);

endmodule

### sim/wheel_cmd_checker.sv
module wheel_cmd_checker
  import fpsc_pkg::*;
#(
  parameter int unsigned BufBytes = BufBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item channel
  input  logic                item_valid_i,
  input  logic                item_ready_i,
  input  logic [KindW-1:0]    item_kind_i,
  input  logic [ByteW-1:0]    item_byte_i,
  // wheel command channel
  input  logic                cmd_valid_i,
  input  logic                cmd_ready_i,
  input  logic [SpeedW-1:0]   cmd_left_i,
  input  logic [SpeedW-1:0]   cmd_right_i,
  input  logic [CauseW-1:0]   cmd_cause_i,
  // register writes
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [SpeedW-1:0] left;
    logic [SpeedW-1:0] right;
    logic [CauseW-1:0] cause;
  } wheel_cmd_t;

  cfg_t              regs;
  logic [LenW-1:0]   rx_count;
  logic [WordW-1:0]  hdr_word;
  logic [WordW-1:0]  xerr_word;
  logic [ByteW-1:0]  status_byte;
  logic [ByteW-1:0]  sum_acc;
  logic [ByteW-1:0]  prev_b;
  logic [ByteW-1:0]  last_b;
  logic [WordW-1:0]  lost_ticks;
  wheel_cmd_t        expected_cmds[$];
  wheel_cmd_t        want;
  wheel_cmd_t        got;
  int unsigned       mismatches;

  function automatic logic [SpeedW-1:0] pct(input int v);
    if (v < 0) return '0;
    if (v > int'(SpeedMax)) return SpeedMax;
    return SpeedW'(v);
  endfunction

  // dead zone, then 0.4 gain truncated toward zero, clamped to the turn limit
  function automatic wheel_cmd_t steer_cmd();
    int x;
    int dz;
    int base;
    int lim;
    int turn;
    wheel_cmd_t cmd;
    x    = $signed(xerr_word);
    dz   = int'(regs.dz_band);
    base = int'(regs.cruise_pct);
    lim  = int'(regs.turn_limit);
    turn = 0;
    if (!(x > -dz && x < dz)) begin
      turn = ((x < 0 ? -x : x) * 2) / 5;
      if (x < 0) turn = -turn;
      if (turn > lim) turn = lim;
      if (turn < -lim) turn = -lim;
    end
    cmd.left  = pct(base - turn);
    cmd.right = pct(base + turn);
    cmd.cause = CauseTrack;
    return cmd;
  endfunction

  task automatic predict_item(input logic [KindW-1:0] kind, input logic [ByteW-1:0] b);
    logic [LenW-1:0]  minlen;
    logic [ByteW-1:0] head_sum;
    logic [WordW:0]   next_ticks;
    bit               frame_ok;
    case (kind)
      KindByte: begin
        if (rx_count < BufBytes) begin
          case (rx_count)
            PosHeaderHi: hdr_word[WordW-1:ByteW]  = b;
            PosHeaderLo: hdr_word[ByteW-1:0]      = b;
            PosErrLo:    xerr_word[ByteW-1:0]     = b;
            PosErrHi:    xerr_word[WordW-1:ByteW] = b;
            PosStatus:   status_byte              = b;
            default: ;
          endcase
          sum_acc  = sum_acc + b;
          prev_b   = last_b;
          last_b   = b;
          rx_count = rx_count + 1'b1;
        end
      end
      KindIdle: begin
        minlen   = (regs.min_frame_len < MinLenFloor) ? MinLenFloor : regs.min_frame_len;
        head_sum = sum_acc - prev_b - last_b;
        frame_ok = rx_count >= minlen && hdr_word == HeaderWord &&
                   last_b == EndByte && head_sum == prev_b;
        rx_count = '0;
        sum_acc  = '0;
        prev_b   = '0;
        last_b   = '0;
        if (frame_ok) begin
          if (status_byte == StatusTrack) begin
            lost_ticks = '0;
            expected_cmds.push_back(steer_cmd());
          end else if (status_byte == StatusLost && lost_ticks == '0) begin
            lost_ticks = 1;
            expected_cmds.push_back('{left: '0, right: '0, cause: CauseLost});
          end
        end
      end
      KindTick: begin
        if (lost_ticks != '0) begin
          next_ticks = {1'b0, lost_ticks} + 1'b1;
          if (next_ticks > {1'b0, regs.lost_timeout} || next_ticks[WordW]) begin
            lost_ticks = '0;
            expected_cmds.push_back('{left: '0, right: '0, cause: CauseTimeout});
          end else begin
            lost_ticks = next_ticks[WordW-1:0];
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.dz_band       = DeadZoneRst;
      regs.cruise_pct    = BaseSpeedRst;
      regs.turn_limit    = MaxTurnRst;
      regs.lost_timeout  = TimeoutRst;
      regs.min_frame_len = MinLenRst;
      rx_count    = '0;
      hdr_word    = '0;
      xerr_word   = '0;
      status_byte = '0;
      sum_acc     = '0;
      prev_b      = '0;
      last_b      = '0;
      lost_ticks  = '0;
      expected_cmds.delete();
      mismatches  = 0;
    end else begin
      // outgoing transfer belongs to an older item, so retire it first
      if (cmd_valid_i && cmd_ready_i) begin
        got = '{left: cmd_left_i, right: cmd_right_i, cause: cmd_cause_i};
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected wheel cmd L%0d R%0d cause %0d",
                     $realtime, got.left, got.right, got.cause);
        end else begin
          want = expected_cmds.pop_front();
          if (want.left != got.left || want.right != got.right || want.cause != got.cause) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: wheel cmd mismatch, exp L%0d R%0d cause %0d, got L%0d R%0d cause %0d",
                       $realtime, want.left, want.right, want.cause,
                       got.left, got.right, got.cause);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegDeadZone:  regs.dz_band       = cfg_data_i[DzW-1:0];
          RegBaseSpeed: regs.cruise_pct    = cfg_data_i[SpeedW-1:0];
          RegMaxTurn:   regs.turn_limit    = cfg_data_i[SpeedW-1:0];
          RegTimeout:   regs.lost_timeout  = cfg_data_i[TimeoutW-1:0];
          RegMinLen:    regs.min_frame_len = cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
      if (item_valid_i && item_ready_i) predict_item(item_kind_i, item_byte_i);
    end
    errors_o  = mismatches;
    pending_o = expected_cmds.size();
  end

endmodule

### sim/tb_frame_parse_steering_control.sv
module tb_frame_parse_steering_control;
  import fpsc_pkg::*;

  // kind code the block must ignore
  localparam logic [KindW-1:0]   KindUnused = 2'd3;
  // register index past the end of the map, writes to it are dropped
  localparam logic [CfgIdxW-1:0] RegUnused  = 3'd5;
  localparam int unsigned        SegItems   = 140;

  logic        clk_i;
  logic        rst_ni;
  int unsigned errors;
  int unsigned pending_cmds;
  int unsigned items_sent;
  int unsigned src_idle;
  int unsigned sink_stall;
  int          dz_now;

  fpsc_in_if  in_if ();
  fpsc_out_if out_if ();
  fpsc_cfg_if cfg_if ();

  frame_parse_steering_control DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Watches all three channels, keeps its own copy of parser and steering
  // state, and checks every wheel command against the predicted one.
  wheel_cmd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_if.valid),
    .item_ready_i (in_if.ready),
    .item_kind_i  (in_if.kind),
    .item_byte_i  (in_if.data_byte),
    .cmd_valid_i  (out_if.valid),
    .cmd_ready_i  (out_if.ready),
    .cmd_left_i   (out_if.left_pct),
    .cmd_right_i  (out_if.right_pct),
    .cmd_cause_i  (out_if.cause),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_index_i  (cfg_if.index),
    .cfg_data_i   (cfg_if.data),
    .errors_o     (errors),
    .pending_o    (pending_cmds)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side back-pressure, redrawn every cycle at the falling edge.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= sink_stall);
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #5_000_000;
    $display("tb_frame_parse_steering_control failed");
    $finish;
  end

  // One item transfer. Entered and left at a falling edge; valid stays high
  // into the next call so back-to-back items go without a bubble.
  task automatic send_item(input logic [KindW-1:0] kind, input logic [ByteW-1:0] byte_val);
    while ($urandom_range(0, 99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.data_byte <= byte_val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (kind != KindUnused) items_sent++;
    @(negedge clk_i);
  endtask

  // Wait until every predicted command has come out, then let the block finish
  // the items that produce nothing.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_cmds != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_regs(input logic [CfgDataW-1:0] dz, input logic [CfgDataW-1:0] base,
                            input logic [CfgDataW-1:0] turn, input logic [CfgDataW-1:0] tmo,
                            input logic [CfgDataW-1:0] minlen);
    cfg_write(RegDeadZone, dz);
    cfg_write(RegBaseSpeed, base);
    cfg_write(RegMaxTurn, turn);
    cfg_write(RegTimeout, tmo);
    cfg_write(RegMinLen, minlen);
    dz_now = int'(dz[DzW-1:0]);
  endtask

  // Builds a burst: header, x error, status, filler, checksum, end byte.
  // junk appends bytes past the store depth; spoil flips one byte.
  task automatic send_frame(input int len, input logic [ByteW-1:0] status,
                            input logic [WordW-1:0] xerr, input int junk, input bit spoil);
    logic [ByteW-1:0] fb [0:BufBytesDef-1];
    logic [ByteW-1:0] acc;
    int k;
    for (k = 0; k < BufBytesDef; k++) fb[k] = ByteW'($urandom);
    fb[PosHeaderHi] = HeaderWord[WordW-1:ByteW];
    fb[PosHeaderLo] = HeaderWord[ByteW-1:0];
    fb[PosErrLo]    = xerr[ByteW-1:0];
    fb[PosErrHi]    = xerr[WordW-1:ByteW];
    fb[PosStatus]   = status;
    if (len >= 2) begin
      acc = '0;
      for (k = 0; k < len - 2; k++) acc = acc + fb[k];
      fb[len-2] = acc;
      fb[len-1] = EndByte;
    end
    if (spoil) fb[$urandom_range(0, len - 1)] ^= ByteW'($urandom_range(1, 255));
    for (k = 0; k < len; k++) send_item(KindByte, fb[k]);
    repeat (junk) send_item(KindByte, ByteW'($urandom));
    send_item(KindIdle, ByteW'($urandom));
  endtask

  // x error: inside, on and outside the dead zone, plus both rails
  function automatic logic [WordW-1:0] pick_xerr();
    int v;
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, 2 * dz_now)) - dz_now;
      1: v = ($urandom_range(0, 1) ? 1 : -1) * (dz_now - int'($urandom_range(0, 1)));
      2: v = $urandom_range(0, 1) ? 32767 : -32768;
      3: v = int'($urandom_range(0, 400)) - 200;
      default: v = int'($urandom);
    endcase
    return WordW'(v);
  endfunction

  function automatic logic [ByteW-1:0] pick_status();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return StatusTrack;
    if (p < 85) return StatusLost;
    return ByteW'($urandom_range(2, 255));
  endfunction

  // One random slice of traffic; mostly well-formed frames so the
  // checksum, steering and lost-counter paths get exercised.
  task automatic random_group();
    int unsigned r;
    int          len;
    int          junk;
    r    = $urandom_range(0, 99);
    junk = 0;
    if (r < 60) begin
      case ($urandom_range(0, 9))
        7, 8: len = $urandom_range(15, BufBytesDef);
        9: begin
          len  = BufBytesDef;
          junk = $urandom_range(0, 4);
        end
        default: len = $urandom_range(9, 14);
      endcase
      send_frame(len, pick_status(), pick_xerr(), junk, 1'b0);
    end else if (r < 75) begin
      send_frame($urandom_range(1, BufBytesDef), pick_status(), pick_xerr(), 0, 1'b1);
    end else if (r < 90) begin
      repeat ($urandom_range(1, 6)) send_item(KindTick, ByteW'($urandom));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          repeat ($urandom_range(1, 5)) send_item(KindByte, ByteW'($urandom));
          send_item(KindIdle, ByteW'($urandom));
        end
        1: send_item(KindIdle, ByteW'($urandom));
        default: send_item(KindUnused, ByteW'($urandom));
      endcase
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.kind      = KindByte;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = RegDeadZone;
    cfg_if.data     = '0;
    src_idle        = 0;
    sink_stall      = 0;
    items_sent      = 0;
    dz_now          = int'(DeadZoneRst);
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed, reset register values: ignored kind, empty burst end,
    // tick with no counter running, a loss brake, then a tracking frame
    // at the negative rail which also clears the lost counter.
    send_item(KindUnused, 8'hFF);
    send_item(KindIdle, 8'h00);
    send_item(KindTick, 8'h00);
    send_frame(9, StatusLost, 16'h7FFF, 0, 1'b0);
    send_frame(9, StatusTrack, 16'h8000, 0, 1'b0);

    // Random segments: each one reprograms the registers while idle and
    // picks one of the idling patterns.
    for (int seg = 0; seg < 8; seg++) begin
      settle();
      case (seg)
        0: apply_regs(16'd0, 16'd0, 16'd0, 16'd1, 16'd9);
        1: apply_regs(16'd32767, 16'd100, 16'd100, 16'd65534, 16'd30);
        2: apply_regs(16'd10, 16'd60, 16'd40, 16'd3, 16'd3);   // minimum below floor
        4: begin
          // upper bits beyond each register are dropped
          apply_regs(16'h8005, 16'hFF3C, 16'h0F28, 16'($urandom_range(2, 12)), 16'h002B);
          cfg_write(RegUnused, 16'($urandom));
        end
        6: apply_regs(16'd1, 16'd100, 16'd0, 16'd2, 16'd31);  // minimum above store
        default: apply_regs(16'($urandom_range(0, 300)), 16'($urandom_range(0, 100)),
                            16'($urandom_range(0, 100)), 16'($urandom_range(1, 20)),
                            16'($urandom_range(9, 14)));
      endcase
      case (seg % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 86; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 86; end
        default: begin src_idle = 24; sink_stall = 24; end
      endcase
      for (int unsigned target = items_sent + SegItems; items_sent < target; )
        random_group();
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_frame_parse_steering_control passed");
    end else begin
      $display("tb_frame_parse_steering_control failed");
    end
    $finish;
  end

endmodule

### frame_parse_steering_control.f
hw/rtl/fpsc_pkg.sv
hw/rtl/fpsc_intf.sv
hw/rtl/fpsc_cfg_regs.sv
hw/rtl/fpsc_frame.sv
hw/rtl/fpsc_steer.sv
hw/rtl/frame_parse_steering_control.sv
sim/wheel_cmd_checker.sv
sim/tb_frame_parse_steering_control.sv
